### rtl/b64d_pkg.sv
// Package for the Base64 stream decoder: item and result types, status codes,
// queue sizing and the alphabet lookup. No dependencies.
`default_nettype none
package b64d_pkg;

    localparam int MAX_RES  = 4;
    localparam int NUM_W    = $clog2(MAX_RES + 1);
    localparam int RQ_DEPTH = 8;
    localparam int RQ_AW    = $clog2(RQ_DEPTH);
    localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_CHAR = 2'd1;
    localparam logic [1:0] ST_BAD_LEN  = 2'd2;
    localparam logic [1:0] ST_OVER     = 2'd3;

    typedef struct packed {
        logic       has_char;
        logic [7:0] char_code;
        logic       end_of_text;
    } t_item;

    typedef struct packed {
        logic        is_data;
        logic [7:0]  data_byte;
        logic        final_mark;
        logic [1:0]  status;
        logic [15:0] byte_count;
    } t_result;

    typedef struct packed {
        t_result [MAX_RES-1:0] res;
        logic [NUM_W-1:0]      num;
    } t_batch;

    typedef struct packed {
        logic [RQ_CW-1:0] count;
        logic [RQ_CW-1:0] free;
    } t_rq_stat;

    // Returns {valid, sextet} for one character of the standard alphabet.
    function automatic logic [6:0] sextet_lookup(input logic [7:0] c);
        logic [6:0] r;
        r = 7'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = {1'b1, 6'(c - 8'h41)};
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r = {1'b1, 6'(c - 8'h61 + 8'd26)};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 6'(c - 8'h30 + 8'd52)};
        end else if (c == 8'h2B) begin
            r = {1'b1, 6'd62};
        end else if (c == 8'h2F) begin
            r = {1'b1, 6'd63};
        end
        return r;
    endfunction

    function automatic t_result data_result(input logic [7:0] b);
        t_result r;
        r            = '0;
        r.is_data    = 1'b1;
        r.data_byte  = b;
        return r;
    endfunction

endpackage
`default_nettype wire

### rtl/b64d_ifs.sv
// Handshake channel interfaces for the Base64 stream decoder: input items,
// result items and the configuration write channel. No dependencies.
`default_nettype none
interface b64d_in_if;
    logic       valid;
    logic       ready;
    logic       has_char;
    logic [7:0] char_code;
    logic       end_of_text;
    modport source (output valid, has_char, char_code, end_of_text, input ready);
    modport sink (input valid, has_char, char_code, end_of_text, output ready);
endinterface

interface b64d_out_if;
    logic        valid;
    logic        ready;
    logic        is_data;
    logic [7:0]  data_byte;
    logic        final_mark;
    logic [1:0]  status;
    logic [15:0] byte_count;
    modport source (output valid, is_data, data_byte, final_mark, status, byte_count,
                    input ready);
    modport sink (input valid, is_data, data_byte, final_mark, status, byte_count,
                  output ready);
endinterface

interface b64d_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] output_limit;
    modport source (output valid, output_limit, input ready);
    modport sink (input valid, output_limit, output ready);
endinterface
`default_nettype wire

### rtl/base64_stream_decoder.sv
// Base64 stream decoder top level: input register, decode stage, result
// queue and the output limit register. Depends on b64d_pkg, b64d_ifs,
// b64d_core and b64d_rq.
//
// The block takes one item per cycle on i_in while i_in.ready is high: a
// character, an end-only item, or a character with end_of_text set. Each
// complete quad gives three data results unless a bad character was seen in
// the text; the item that ends the text gives any pad bytes and then one end
// result carrying status and byte count. Results leave on o_out one per cycle
// while o_out.ready is high.
// Throughput: one item per cycle, set by the single decode stage; an item
// waits in the input register and is decoded into the result queue only
// while the eight-entry queue has room for four results. When the receiver
// stalls, results collect in the queue and i_in.ready drops once the input
// register holds an item that cannot be decoded. i_cfg writes output_limit;
// it is always ready and should be written only while the block is idle.
// Reset (synchronous, active low) clears the stream state and the queue and
// sets output_limit to 65535.
`default_nettype none
module base64_stream_decoder (
    input  logic              i_clk,
    input  logic              i_rst_n,
    b64d_in_if.sink           i_in,
    b64d_out_if.source        o_out,
    b64d_cfg_if.sink          i_cfg
);
    import b64d_pkg::*;

    logic        r_in_valid;
    t_item       r_item;
    logic [15:0] r_limit;
    logic        proc_fire;
    logic        in_fire;
    t_batch      batch;
    t_result     head;
    t_rq_stat    q_stat;

    assign proc_fire  = r_in_valid && (q_stat.free >= RQ_CW'(MAX_RES));
    assign i_in.ready = !r_in_valid || proc_fire;
    assign in_fire    = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_limit    <= 16'hFFFF;
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (proc_fire) begin
                r_in_valid <= 1'b0;
            end
            if (i_cfg.valid) begin
                r_limit <= i_cfg.output_limit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_item.has_char    <= i_in.has_char;
            r_item.char_code   <= i_in.char_code;
            r_item.end_of_text <= i_in.end_of_text;
        end
    end

    b64d_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (proc_fire),
        .i_item  (r_item),
        .i_limit (r_limit),
        .o_batch (batch)
    );

    b64d_rq u_rq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (proc_fire),
        .i_batch (batch),
        .i_pop   (o_out.ready),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    assign o_out.valid      = (q_stat.count != RQ_CW'(0));
    assign o_out.is_data    = head.is_data;
    assign o_out.data_byte  = head.data_byte;
    assign o_out.final_mark = head.final_mark;
    assign o_out.status     = head.status;
    assign o_out.byte_count = head.byte_count;

    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.count <= RQ_CW'(RQ_DEPTH))
        else $error("result queue count beyond its depth");

    a_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_fire |-> (q_stat.free >= RQ_CW'(MAX_RES)))
        else $error("item decoded without room for its results");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !proc_fire) |=> r_in_valid)
        else $error("waiting item dropped from the input register");

    a_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.final_mark) |-> !o_out.is_data)
        else $error("end result marked as data");

endmodule
`default_nettype wire

### rtl/b64d_core.sv
// Decode stage: holds the stream state and turns one registered item into a
// batch of up to four results. Depends on b64d_pkg.
`default_nettype none
module b64d_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  b64d_pkg::t_item  i_item,
    input  logic [15:0]      i_limit,
    output b64d_pkg::t_batch o_batch
);
    import b64d_pkg::*;

    logic [17:0] r_buf, n_buf;
    logic [1:0]  r_qpos, n_qpos;
    logic [1:0]  r_pad_run, n_pad_run;
    logic [1:0]  r_pad_start, n_pad_start;
    logic        r_bad, n_bad;
    logic [15:0] r_count, n_count;

    logic [6:0]  look;
    logic [5:0]  sextet;
    logic [23:0] triple;
    logic [3:0]  add;
    logic [16:0] sum;
    logic [15:0] cnt_sat;
    logic        emit3;
    logic [1:0]  pad_n;
    logic [1:0]  status;
    t_result     end_res;
    t_result     pb0;
    t_result     pb1;

    always_comb begin
        n_buf       = r_buf;
        n_qpos      = r_qpos;
        n_pad_run   = r_pad_run;
        n_pad_start = r_pad_start;
        n_bad       = r_bad;
        add         = 4'd0;
        emit3       = 1'b0;
        pad_n       = 2'd0;
        look        = sextet_lookup(i_item.char_code);
        sextet      = look[6] ? look[5:0] : 6'd0;
        triple      = {r_buf, sextet};

        if (i_item.has_char) begin
            if (i_item.char_code == PAD_CHAR) begin
                if (r_pad_run == 2'd0) begin
                    n_pad_start = r_qpos;
                end
                if (r_pad_run < 2'd2) begin
                    n_pad_run = r_pad_run + 2'd1;
                    if (r_qpos == 2'd3) begin
                        n_qpos = 2'd0;
                    end else begin
                        n_buf  = {r_buf[11:0], 6'd0};
                        n_qpos = r_qpos + 2'd1;
                    end
                end
            end else begin
                if (!look[6]) begin
                    n_bad = 1'b1;
                end
                if (r_pad_run != 2'd0) begin
                    n_bad = 1'b1;
                    if (({1'b0, r_pad_start} + {1'b0, r_pad_run}) >= 3'd4) begin
                        add = add + 4'd3;
                    end
                    n_pad_run   = 2'd0;
                    n_pad_start = 2'd0;
                end
                if (r_qpos == 2'd3) begin
                    add    = add + 4'd3;
                    emit3  = !n_bad;
                    n_qpos = 2'd0;
                end else begin
                    n_buf  = {r_buf[11:0], sextet};
                    n_qpos = r_qpos + 2'd1;
                end
            end
        end

        if (i_item.end_of_text && n_qpos == 2'd0 && n_pad_run != 2'd0
                && n_pad_start >= 2'd2) begin
            add   = add + {2'd0, n_pad_start - 2'd1};
            pad_n = n_bad ? 2'd0 : (n_pad_start - 2'd1);
        end

        sum     = {1'b0, r_count} + {13'd0, add};
        cnt_sat = sum[16] ? 16'hFFFF : sum[15:0];
        n_count = cnt_sat;

        priority if (n_qpos != 2'd0) begin
            status = ST_BAD_LEN;
        end else if (({1'b0, cnt_sat} + 17'd1) > {1'b0, i_limit}) begin
            status = ST_OVER;
        end else if (n_bad) begin
            status = ST_BAD_CHAR;
        end else begin
            status = ST_OK;
        end

        end_res            = '0;
        end_res.final_mark = 1'b1;
        end_res.status     = status;
        end_res.byte_count = cnt_sat;
        pb0                = data_result(n_buf[17:10]);
        pb1                = data_result(n_buf[9:2]);

        o_batch = '0;
        if (emit3) begin
            o_batch.res[0] = data_result(triple[23:16]);
            o_batch.res[1] = data_result(triple[15:8]);
            o_batch.res[2] = data_result(triple[7:0]);
            o_batch.res[3] = end_res;
            o_batch.num    = NUM_W'(3) + NUM_W'(i_item.end_of_text);
        end else begin
            o_batch.res[0] = (pad_n != 2'd0) ? pb0 : end_res;
            o_batch.res[1] = (pad_n == 2'd2) ? pb1 : end_res;
            o_batch.res[2] = end_res;
            o_batch.res[3] = end_res;
            o_batch.num    = NUM_W'(pad_n) + NUM_W'(i_item.end_of_text);
        end

        if (i_item.end_of_text) begin
            n_buf       = '0;
            n_qpos      = 2'd0;
            n_pad_run   = 2'd0;
            n_pad_start = 2'd0;
            n_bad       = 1'b0;
            n_count     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf       <= '0;
            r_qpos      <= 2'd0;
            r_pad_run   <= 2'd0;
            r_pad_start <= 2'd0;
            r_bad       <= 1'b0;
            r_count     <= '0;
        end else if (i_fire) begin
            r_buf       <= n_buf;
            r_qpos      <= n_qpos;
            r_pad_run   <= n_pad_run;
            r_pad_start <= n_pad_start;
            r_bad       <= n_bad;
            r_count     <= n_count;
        end
    end

endmodule
`default_nettype wire

### rtl/b64d_rq.sv
// Result queue: takes a batch of up to four results per cycle and hands them
// out one per cycle in order while i_pop is high. Depends on b64d_pkg.
`default_nettype none
module b64d_rq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  b64d_pkg::t_batch   i_batch,
    input  logic               i_pop,
    output b64d_pkg::t_result  o_head,
    output b64d_pkg::t_rq_stat o_stat
);
    import b64d_pkg::*;

    t_result [RQ_DEPTH-1:0] r_mem;
    logic [RQ_AW-1:0]       r_wr;
    logic [RQ_AW-1:0]       r_rd;
    logic [RQ_CW-1:0]       r_cnt;
    logic [NUM_W-1:0]       push_n;
    logic                   pop_ok;

    assign push_n = i_push ? i_batch.num : NUM_W'(0);
    assign pop_ok = i_pop && (r_cnt != RQ_CW'(0));

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RES; k++) begin
            if (k < int'(push_n)) begin
                r_mem[r_wr + RQ_AW'(k)] <= i_batch.res[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + RQ_AW'(push_n);
            r_rd  <= r_rd + RQ_AW'(pop_ok);
            r_cnt <= r_cnt + RQ_CW'(push_n) - RQ_CW'(pop_ok);
        end
    end

    assign o_head       = r_mem[r_rd];
    assign o_stat.count = r_cnt;
    assign o_stat.free  = RQ_CW'(RQ_DEPTH) - r_cnt;

endmodule
`default_nettype wire
